### rtl/core/poly_voice_allocator_top_defines.svh
// Assertion macros for the voice allocator.
`ifndef POLY_VOICE_ALLOCATOR_TOP_DEFINES_SVH
`define POLY_VOICE_ALLOCATOR_TOP_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define PVA_ASSERT(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define PVA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/pva_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pva_pkg;

    localparam int MAX_VOICES_DEF = 8;

    localparam int VLIM_W  = 4;
    localparam int OCT_W   = 3;
    localparam int KLOK_W  = 2;
    localparam int OP_W    = 2;
    localparam int NOTE_W  = 7;
    localparam int VEL_W   = 7;
    localparam int VIDX_W  = 3;
    localparam int OVOICE_W = 3;
    localparam int MASK_W  = 8;
    localparam int CNT_W   = 8;
    localparam int LIM_W   = 6;
    localparam int ADJ_W   = 9;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam int REGIDX_W = 2;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    localparam logic [VLIM_W-1:0] VLIM_RESET = 4'd8;

    typedef enum logic [OP_W-1:0] {
        OP_NOTE_ON  = 2'd0,
        OP_NOTE_OFF = 2'd1,
        OP_ALL_OFF  = 2'd2,
        OP_STATUS   = 2'd3
    } opcode_t;

    typedef enum logic [REGIDX_W-1:0] {
        REG_VOICE_LIMIT  = 2'd0,
        REG_OCTAVE_SHIFT = 2'd1,
        REG_KLOK_SETTING = 2'd2,
        REG_UNUSED       = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [VLIM_W-1:0] voice_limit;
        logic [OCT_W-1:0]  octave_shift;
        logic [KLOK_W-1:0] klok_setting;
    } cfg_t;

    // Packed from the top down: first field ends up in the highest bits.
    typedef struct packed {
        logic              voice_sounding;
        logic [VIDX_W-1:0] voice_index;
        logic [VEL_W-1:0]  velocity;
        logic [NOTE_W-1:0] note;
    } in_item_t;

    typedef struct packed {
        logic [KLOK_W-1:0]   klok_latched;
        logic                filter_gate_off;
        logic                filter_gate_on;
        logic [MASK_W-1:0]   gate_off_mask;
        logic                pitch_valid;
        logic [NOTE_W-1:0]   pitch;
        logic [OVOICE_W-1:0] assigned_voice;
        logic                gate_on_valid;
    } result_t;

    localparam int IN_ITEM_W = $bits(in_item_t);

    typedef struct packed {
        logic load;
        logic exec;
    } pva_cmd_t;

endpackage

`default_nettype wire

### rtl/core/pva_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module pva_regs
    import pva_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output cfg_t                    cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;

    assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite && pready)
        begin
            unique case (idx)
                REG_VOICE_LIMIT:  cfg_next.voice_limit  = pwdata[VLIM_W-1:0];
                REG_OCTAVE_SHIFT: cfg_next.octave_shift = pwdata[OCT_W-1:0];
                REG_KLOK_SETTING: cfg_next.klok_setting = pwdata[KLOK_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_VOICE_LIMIT:  prdata = PDATA_W'(cfg_reg.voice_limit);
            REG_OCTAVE_SHIFT: prdata = PDATA_W'(cfg_reg.octave_shift);
            REG_KLOK_SETTING: prdata = PDATA_W'(cfg_reg.klok_setting);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.voice_limit  <= VLIM_RESET;
            cfg_reg.octave_shift <= '0;
            cfg_reg.klok_setting <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/pva_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module pva_ctrl
    import pva_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  wire logic m_ready,
    output pva_cmd_t  cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = out_valid_reg;
    assign cmd.load = s_valid && (state_reg == ST_IDLE);
    assign cmd.exec = (state_reg == ST_EXEC) && (!out_valid_reg || m_ready);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (cmd.exec)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/pva_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module pva_datapath
    import pva_pkg::*;
#(
    parameter int MAX_VOICES = MAX_VOICES_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire pva_cmd_t cmd,
    input  wire cfg_t     cfg,
    input  wire in_item_t in_item,
    input  wire opcode_t  in_op,
    output result_t       result
);

    localparam int VW    = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
    localparam int EXT_W = MAX_VOICES + MASK_W;
    localparam logic [LIM_W-1:0] MAXV = LIM_W'(MAX_VOICES);

    in_item_t item_reg;
    opcode_t  op_reg;
    result_t  res_reg;
    result_t  res_next;

    logic [NOTE_W-1:0]     note_reg  [MAX_VOICES];
    logic [NOTE_W-1:0]     note_next [MAX_VOICES];
    logic [MAX_VOICES-1:0] gate_reg;
    logic [MAX_VOICES-1:0] gate_next;
    logic [MAX_VOICES-1:0] play_reg;
    logic [MAX_VOICES-1:0] play_next;
    logic [VW-1:0]         rr_reg;
    logic [VW-1:0]         rr_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic [KLOK_W-1:0]     klok_reg;
    logic [KLOK_W-1:0]     klok_next;

    logic [LIM_W-1:0]      lim;
    logic [MAX_VOICES-1:0] active;
    logic [MAX_VOICES-1:0] free_idle;
    logic [MAX_VOICES-1:0] free_open;
    logic [MAX_VOICES-1:0] close_vec;
    logic [EXT_W-1:0]      close_ext;
    logic                  found_idle;
    logic                  found_open;
    logic [VW-1:0]         pick_idle;
    logic [VW-1:0]         pick_open;
    logic [VW-1:0]         rr_pick;
    logic [LIM_W-1:0]      rr_inc;
    logic [VW-1:0]         assigned;
    logic signed [3:0]     oct_sum;
    logic signed [ADJ_W-1:0] oct9;
    logic signed [ADJ_W-1:0] adj;
    logic                  adj_ok;
    logic [CNT_W-1:0]      cnt_inc;
    logic [CNT_W-1:0]      cnt_dec;
    logic                  is_on;
    logic                  is_off;

    assign result = res_reg;

    always_comb
    begin
        if (cfg.voice_limit == '0)
            lim = LIM_W'(1);
        else if (LIM_W'(cfg.voice_limit) > MAXV)
            lim = MAXV;
        else
            lim = LIM_W'(cfg.voice_limit);
    end

    // voice search: highest-numbered match wins
    always_comb
    begin
        found_idle = 1'b0;
        found_open = 1'b0;
        pick_idle  = '0;
        pick_open  = '0;
        for (int v = 0; v < MAX_VOICES; v++)
        begin
            active[v]    = LIM_W'(v) < lim;
            free_idle[v] = active[v] && !play_reg[v] && !gate_reg[v];
            free_open[v] = active[v] && !gate_reg[v];
            if (free_idle[v])
            begin
                found_idle = 1'b1;
                pick_idle  = VW'(v);
            end
            if (free_open[v])
            begin
                found_open = 1'b1;
                pick_open  = VW'(v);
            end
        end
    end

    assign rr_pick = (LIM_W'(rr_reg) < lim) ? rr_reg : '0;
    assign rr_inc  = LIM_W'(rr_pick) + LIM_W'(1);
    assign assigned = found_idle ? pick_idle : (found_open ? pick_open : rr_pick);

    // pitch = note + 12 * (octave + klok)
    assign oct_sum = 4'(signed'(cfg.octave_shift)) + signed'({2'b00, cfg.klok_setting});
    assign oct9    = ADJ_W'(oct_sum);
    assign adj     = signed'(ADJ_W'(item_reg.note)) + (oct9 <<< 3) + (oct9 <<< 2);
    assign adj_ok  = !adj[ADJ_W-1] && !adj[ADJ_W-2];

    assign cnt_inc = cnt_reg + CNT_W'(1);
    assign cnt_dec = cnt_reg - CNT_W'(1);

    assign is_on  = (op_reg == OP_NOTE_ON) && (item_reg.velocity != '0);
    assign is_off = ((op_reg == OP_NOTE_ON) && (item_reg.velocity == '0))
                    || (op_reg == OP_NOTE_OFF);

    always_comb
    begin
        for (int v = 0; v < MAX_VOICES; v++)
        begin
            note_next[v] = note_reg[v];
        end
        gate_next = gate_reg;
        play_next = play_reg;
        rr_next   = rr_reg;
        cnt_next  = cnt_reg;
        klok_next = klok_reg;
        close_vec = '0;
        res_next  = '0;

        if (is_on)
        begin
            klok_next = cfg.klok_setting;
            if (!found_idle && !found_open)
            begin
                rr_next = (rr_inc == lim) ? '0 : VW'(rr_inc);
            end
            for (int v = 0; v < MAX_VOICES; v++)
            begin
                if (assigned == VW'(v))
                begin
                    note_next[v] = item_reg.note;
                end
            end
            res_next.assigned_voice = OVOICE_W'(assigned);
            if (adj_ok)
            begin
                res_next.pitch       = adj[NOTE_W-1:0];
                res_next.pitch_valid = 1'b1;
                if (!gate_reg[assigned])
                begin
                    gate_next[assigned]     = 1'b1;
                    res_next.gate_on_valid  = 1'b1;
                    cnt_next                = cnt_inc;
                    res_next.filter_gate_on = !cnt_inc[CNT_W-1] && (cnt_inc != '0);
                end
            end
        end
        else if (is_off)
        begin
            for (int v = 0; v < MAX_VOICES; v++)
            begin
                close_vec[v] = active[v] && (note_reg[v] == item_reg.note);
            end
            gate_next                = gate_reg & ~close_vec;
            cnt_next                 = cnt_dec;
            res_next.filter_gate_off = (cnt_dec == '0);
        end
        else if (op_reg == OP_ALL_OFF)
        begin
            close_vec                = active;
            gate_next                = gate_reg & ~active;
            cnt_next                 = '0;
            res_next.filter_gate_off = 1'b1;
        end
        else
        begin
            for (int v = 0; v < MAX_VOICES; v++)
            begin
                if (LIM_W'(item_reg.voice_index) == LIM_W'(v))
                begin
                    play_next[v] = item_reg.voice_sounding;
                end
            end
        end

        close_ext              = EXT_W'(close_vec);
        res_next.gate_off_mask = close_ext[MASK_W-1:0];
        res_next.klok_latched  = klok_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int v = 0; v < MAX_VOICES; v++)
            begin
                note_reg[v] <= '0;
            end
            gate_reg <= '0;
            play_reg <= '0;
            rr_reg   <= '0;
            cnt_reg  <= '0;
            klok_reg <= '0;
        end
        else if (cmd.exec)
        begin
            for (int v = 0; v < MAX_VOICES; v++)
            begin
                note_reg[v] <= note_next[v];
            end
            gate_reg <= gate_next;
            play_reg <= play_next;
            rr_reg   <= rr_next;
            cnt_reg  <= cnt_next;
            klok_reg <= klok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_item;
            op_reg   <= in_op;
        end
        if (cmd.exec)
        begin
            res_reg <= res_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/poly_voice_allocator_top.sv
// Channel   Dir  Data                                           Transfer
// s_axis    in   tdata: note, velocity, voice_index, sounding   tvalid & tready
//                tuser: opcode
// m_axis    out  tdata: one result per input item               tvalid & tready
// apb       in   voice_limit @0x0, octave_shift @0x4, klok @0x8  psel & penable & pwrite
//
// Each item is first captured, then run through the voice search and state update
// in the datapath's execute step; no new item is taken until it leaves that step.
// The result sits in an output register; a new item is taken while it waits.
// A stalled output holds the item in the execute step until the register frees.
// rst_n clears all voice state and resets the configuration registers (voice_limit to 8) at once.
`timescale 1ns / 1ps
`default_nettype none

module poly_voice_allocator_top
    import pva_pkg::*;
#(
    parameter int MAX_VOICES = MAX_VOICES_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // note[6:0], velocity[13:7], voice_index[16:14], voice_sounding[17]
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // opcode[1:0]
    input  wire logic [OP_W-1:0]        s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // gate_on_valid[0], assigned_voice[3:1], pitch[10:4], pitch_valid[11],
    // gate_off_mask[19:12], filter_gate_on[20], filter_gate_off[21],
    // klok_latched[23:22]
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [PADDR_W-1:0]     paddr,
    input  wire logic [PDATA_W-1:0]     pwdata,
    output logic      [PDATA_W-1:0]     prdata,
    output logic                        pready
);

    cfg_t     cfg;
    pva_cmd_t cmd;
    result_t  result;

    pva_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pva_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .cmd     (cmd)
    );

    pva_datapath #(
        .MAX_VOICES (MAX_VOICES)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .cfg     (cfg),
        .in_item (in_item_t'(s_axis_tdata[IN_ITEM_W-1:0])),
        .in_op   (opcode_t'(s_axis_tuser)),
        .result  (result)
    );

    assign m_axis_tdata = OUT_TDATA_W'(result);

endmodule

`default_nettype wire

### rtl/core/pva_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "poly_voice_allocator_top_defines.svh"

module pva_checker
    import pva_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   s_axis_tvalid,
    input wire logic                   s_axis_tready,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    `PVA_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while busy")
    `PVA_ASSERT(a_on_has_pitch, !(m_axis_tvalid && m_axis_tdata[0]) || m_axis_tdata[11], "gate on without valid pitch")
    `PVA_ASSERT(a_on_xor_off, !(m_axis_tvalid && m_axis_tdata[0] && (m_axis_tdata[19:12] != '0)), "gate on and gate off in one result")
    `PVA_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

bind poly_voice_allocator_top pva_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
